### hw/rtl/acb_pkg.sv
// shared types, constants and helpers for the alpha colour bleed 3x3 unit
// no dependencies
`default_nettype none

package acb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = 11;
   localparam int IROW_W = OROW_W + 1;
   localparam int THR_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET     = 11'd1024;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 11'd1024;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type mid;
      pixel_type up;
   } line_word_type;

   typedef struct packed {
      logic             emit;
      logic             eof;
      logic             top;
      logic             bottom;
      logic             left;
      logic             right;
      logic             bypass;
      logic [COL_W-1:0] addr;
   } s1_ctrl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic is_source(input pixel_type p, input logic [THR_W-1:0] thr);
      return (p.alpha > thr) || (p.red != 8'd0);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/acb_req_if.sv
// pixel request channel: valid/ready handshake with rgba payload and flush flag
// no dependencies
`default_nettype none

interface acb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       flush;

   modport source (output valid, red, green, blue, alpha, flush, input ready);
   modport sink   (input valid, red, green, blue, alpha, flush, output ready);
endinterface

`default_nettype wire

### hw/rtl/acb_rsp_if.sv
// pixel response channel: valid/ready handshake with bled rgba and end of frame
// no dependencies
`default_nettype none

interface acb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       end_of_frame;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/alpha_colour_bleed_3x3_unit.sv
// alpha colour bleed 3x3 top level: line memory, window and bleed select
// depends on acb_pkg, acb_req_if, acb_rsp_if
//
// rgba pixels enter on req in raster order, one transaction per pixel; a
// flush transaction carries no pixel and drains the frame tail (width+1 of
// them after the last pixel). each transaction on req yields the result for
// the pixel width+1 positions earlier on rsp; the first width+1 give none.
// a transparent pixel takes the rgb of the nearest source in its clipped 3x3
// window, alpha passes through, end_of_frame marks the last pixel.
// throughput is one transaction per cycle while rsp takes results, set by
// the line memory with one read at accept and one write back when the
// middle stage moves on. rsp.valid rises once an emitting item has passed
// the input register and then the output register.
// when rsp stalls the output register holds and req.ready drops once the
// middle stage is also full; a new transaction is taken while a result waits.
// csr writes (width, height, threshold) restart the frame and must only be
// issued while idle. synchronous reset clears the counters and handshake
// state and restores the register defaults; the line memory is not cleared.
`default_nettype none

module alpha_colour_bleed_3x3_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   acb_req_if.sink                             req,
   acb_rsp_if.source                           rsp,
   input  wire logic                           csr_wr_en,
   input  wire logic [acb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [acb_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   // configuration
   logic [acb_pkg::DIM_W-1:0] width_ff, width_in;
   logic [acb_pkg::DIM_W-1:0] height_ff, height_in;
   logic [acb_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                      csr_hit;
   logic [acb_pkg::DIM_W-1:0] w_eff, h_eff;

   // position counters
   logic [acb_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [acb_pkg::IROW_W-1:0] in_row_ff, in_row_in;
   logic [acb_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [acb_pkg::OROW_W-1:0] out_row_ff, out_row_in;

   // middle stage
   logic                   s1_valid_ff, s1_valid_in;
   acb_pkg::s1_ctrl_type   s1_ctrl_ff, s1_ctrl_in;
   acb_pkg::pixel_type     s1_pix_ff;
   acb_pkg::line_word_type rd_ff;
   acb_pkg::line_word_type byp_ff;
   acb_pkg::line_word_type line_cur;
   acb_pkg::line_word_type line_wr;

   acb_pkg::line_word_type line_mem [acb_pkg::MAX_WIDTH];

   // window: left and center columns, rows top/mid/bottom
   acb_pkg::pixel_type win_ff [2][3];
   acb_pkg::pixel_type right_col [3];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   acb_pkg::pixel_type rsp_pix_ff, best;
   logic               rsp_eof_ff;

   logic accept, advance;
   logic emit, eof;
   logic [acb_pkg::DIM_W-1:0] col_inc;
   logic [acb_pkg::DIM_W-1:0] row_inc;
   acb_pkg::pixel_type in_pix;

   assign w_eff = acb_pkg::clamp_dim(width_ff, acb_pkg::DIM_W'(acb_pkg::MAX_WIDTH));
   assign h_eff = acb_pkg::clamp_dim(height_ff, acb_pkg::DIM_W'(acb_pkg::MAX_HEIGHT));

   assign advance   = s1_valid_ff && (!s1_ctrl_ff.emit || !rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   // csr decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      csr_hit   = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            acb_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wr_data;
               csr_hit  = 1'b1;
            end
            acb_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wr_data;
               csr_hit   = 1'b1;
            end
            acb_pkg::CSR_ALPHA_THRESHOLD: begin
               thr_in  = csr_wr_data[acb_pkg::THR_W-1:0];
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // accept side: counters, emit and clipping
   always_comb begin
      in_pix.red   = req.red;
      in_pix.green = req.green;
      in_pix.blue  = req.blue;
      in_pix.alpha = req.alpha;
      if (req.flush || (in_row_ff >= h_eff)) in_pix = '0;

      emit = (in_row_ff >= acb_pkg::IROW_W'(2)) ||
             ((in_row_ff == acb_pkg::IROW_W'(1)) && (in_col_ff != '0));
      eof  = emit && ({1'b0, out_row_ff} == h_eff - acb_pkg::DIM_W'(1)) &&
             ({1'b0, out_col_ff} == w_eff - acb_pkg::DIM_W'(1));

      col_inc = {1'b0, in_col_ff} + acb_pkg::DIM_W'(1);
      in_col_in = col_inc[acb_pkg::COL_W-1:0];
      in_row_in = in_row_ff;
      if (col_inc >= w_eff) begin
         in_col_in = '0;
         in_row_in = in_row_ff + acb_pkg::IROW_W'(1);
      end

      row_inc    = {1'b0, out_row_ff} + acb_pkg::DIM_W'(1);
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (emit) begin
         if ({1'b0, out_col_ff} + acb_pkg::DIM_W'(1) >= w_eff) begin
            out_col_in = '0;
            out_row_in = row_inc[acb_pkg::OROW_W-1:0];
         end else begin
            out_col_in = out_col_ff + acb_pkg::COL_W'(1);
         end
      end

      if (eof) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end

      s1_ctrl_in.emit   = emit;
      s1_ctrl_in.eof    = eof;
      s1_ctrl_in.top    = (out_row_ff == '0);
      s1_ctrl_in.bottom = (row_inc >= h_eff);
      s1_ctrl_in.left   = (out_col_ff == '0);
      s1_ctrl_in.right  = ({1'b0, out_col_ff} + acb_pkg::DIM_W'(1) >= w_eff);
      s1_ctrl_in.bypass = advance && (s1_ctrl_ff.addr == in_col_ff);
      s1_ctrl_in.addr   = in_col_ff;

      s1_valid_in = accept || (s1_valid_ff && !advance);
   end

   // middle stage: line words and window column
   always_comb begin
      line_cur = s1_ctrl_ff.bypass ? byp_ff : rd_ff;
      line_wr.up  = line_cur.mid;
      line_wr.mid = s1_pix_ff;
      right_col[0] = line_cur.up;
      right_col[1] = line_cur.mid;
      right_col[2] = s1_pix_ff;
   end

   // nearest source: a center that is a source keeps its color, then edge
   // neighbors before corners, scan order within each
   always_comb begin
      best = win_ff[1][1];
      if ((win_ff[1][1].alpha < thr_ff) && !acb_pkg::is_source(win_ff[1][1], thr_ff)) begin
         if (!s1_ctrl_ff.top && acb_pkg::is_source(win_ff[1][0], thr_ff))
            best = win_ff[1][0];
         else if (!s1_ctrl_ff.left && acb_pkg::is_source(win_ff[0][1], thr_ff))
            best = win_ff[0][1];
         else if (!s1_ctrl_ff.right && acb_pkg::is_source(right_col[1], thr_ff))
            best = right_col[1];
         else if (!s1_ctrl_ff.bottom && acb_pkg::is_source(win_ff[1][2], thr_ff))
            best = win_ff[1][2];
         else if (!s1_ctrl_ff.top && !s1_ctrl_ff.left &&
                  acb_pkg::is_source(win_ff[0][0], thr_ff))
            best = win_ff[0][0];
         else if (!s1_ctrl_ff.top && !s1_ctrl_ff.right &&
                  acb_pkg::is_source(right_col[0], thr_ff))
            best = right_col[0];
         else if (!s1_ctrl_ff.bottom && !s1_ctrl_ff.left &&
                  acb_pkg::is_source(win_ff[0][2], thr_ff))
            best = win_ff[0][2];
         else if (!s1_ctrl_ff.bottom && !s1_ctrl_ff.right &&
                  acb_pkg::is_source(right_col[2], thr_ff))
            best = right_col[2];
      end
      best.alpha = win_ff[1][1].alpha;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (advance && s1_ctrl_ff.emit) rsp_valid_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= acb_pkg::WIDTH_RESET;
         height_ff    <= acb_pkg::HEIGHT_RESET;
         thr_ff       <= acb_pkg::THRESHOLD_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_hit) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (accept) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_pix_ff  <= in_pix;
         byp_ff     <= line_wr;
      end
      if (advance) begin
         win_ff[0][0] <= win_ff[1][0];
         win_ff[0][1] <= win_ff[1][1];
         win_ff[0][2] <= win_ff[1][2];
         win_ff[1][0] <= right_col[0];
         win_ff[1][1] <= right_col[1];
         win_ff[1][2] <= right_col[2];
      end
      if (advance && s1_ctrl_ff.emit) begin
         rsp_pix_ff <= best;
         rsp_eof_ff <= s1_ctrl_ff.eof;
      end
   end

   // line memory: read at accept, write back when the middle stage moves on
   always_ff @(posedge clock) begin
      if (advance) line_mem[s1_ctrl_ff.addr] <= line_wr;
      if (accept)  rd_ff <= line_mem[in_col_ff];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_red      = rsp_pix_ff.red;
   assign rsp.out_green    = rsp_pix_ff.green;
   assign rsp.out_blue     = rsp_pix_ff.blue;
   assign rsp.out_alpha    = rsp_pix_ff.alpha;
   assign rsp.end_of_frame = rsp_eof_ff;

`ifndef SYNTH
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s1_valid_ff)
      else $error("req stalled with empty middle stage");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && eof) |=> (in_col_ff == '0) && (in_row_ff == '0) &&
                          (out_col_ff == '0) && (out_row_ff == '0))
      else $error("counters not cleared after end of frame");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, in_col_ff} < w_eff)
      else $error("input column beyond frame width");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_ctrl_ff.emit))
      else $error("result raised by a non emitting item");
`endif

endmodule

`default_nettype wire
